// ===== design/pes_pkg.sv =====
`default_nettype none
package pes_pkg;

	localparam int ID_W       = 16;
	localparam int PERIOD_W   = 16;
	localparam int OUT_TIME_W = 48;

	localparam logic [1:0] STATUS_REGISTERED = 2'd0;
	localparam logic [1:0] STATUS_FIRED      = 2'd1;
	localparam logic [1:0] STATUS_FULL       = 2'd2;
	localparam logic [1:0] STATUS_EMPTY      = 2'd3;

	localparam logic MODE_REGISTER = 1'b0;
	localparam logic MODE_NEXT     = 1'b1;

	typedef struct packed {
		logic wr;
		logic adv;
	} cell_cmd_t;

endpackage
`default_nettype wire

// ===== design/periodic_event_scheduler.sv =====
// Channel   Handshake                  Payload
// input     in_valid / in_ready        mode, entry_id, period
// output    out_valid / out_ready      status, fired_id, fire_time
//
// One item is in work at a time, and a new transfer is taken only while idle.
// A register transfer enters the busy state and registers its result when that state ends.
// A next transfer stays busy while the earliest candidate travels down the row of slot cells,
// one cell per cycle, and then registers its result from the last cell.
// Reset clears all slots to empty at once. Work that ends while the previous result still
// waits for out_ready is held until that result is taken.
`default_nettype none
module periodic_event_scheduler #(
	parameter int ENTRIES    = 16,
	parameter int TIME_WIDTH = 48
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            in_valid,
	output logic                           in_ready,
	input  wire                            mode,
	input  wire  [pes_pkg::ID_W-1:0]       entry_id,
	input  wire  [pes_pkg::PERIOD_W-1:0]   period,
	output logic                           out_valid,
	input  wire                            out_ready,
	output logic [1:0]                     status,
	output logic [pes_pkg::ID_W-1:0]       fired_id,
	output logic [pes_pkg::OUT_TIME_W-1:0] fire_time
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_BUSY = 2'b10
	} state_t;

	state_t                       state_q;
	logic [CW-1:0]                cnt_q;
	logic [CW-1:0]                count_q;
	logic                         mode_q;
	logic [pes_pkg::ID_W-1:0]     id_q;
	logic [pes_pkg::PERIOD_W-1:0] per_q;

	logic                         cand_vld  [ENTRIES+1];
	logic [TIME_WIDTH-1:0]        cand_time [ENTRIES+1];
	logic [pes_pkg::ID_W-1:0]     cand_id   [ENTRIES+1];
	logic [IW-1:0]                cand_idx  [ENTRIES+1];
	pes_pkg::cell_cmd_t           cmd       [ENTRIES];

	logic          in_xfer;
	logic          target_hit;
	logic          finish;
	logic          full;
	logic [63:0]   best_time64;
	logic [IW-1:0] wr_idx;

	assign in_ready   = (state_q == ST_IDLE);
	assign in_xfer    = in_valid && in_ready;
	assign target_hit = (mode_q == pes_pkg::MODE_REGISTER) ? 1'b1 : (cnt_q == CW'(ENTRIES));
	assign finish     = (state_q == ST_BUSY) && target_hit && (!out_valid || out_ready);
	assign full       = (count_q == CW'(ENTRIES));
	assign wr_idx     = count_q[IW-1:0];
	assign best_time64 = 64'(cand_time[ENTRIES]);

	assign cand_vld[0]  = 1'b0;
	assign cand_time[0] = '0;
	assign cand_id[0]   = '0;
	assign cand_idx[0]  = '0;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		assign cmd[i] = '{
			wr:  finish && (mode_q == pes_pkg::MODE_REGISTER) && !full &&
			     (wr_idx == IW'(i)),
			adv: finish && (mode_q == pes_pkg::MODE_NEXT) && cand_vld[ENTRIES] &&
			     (cand_idx[ENTRIES] == IW'(i))
		};

		pes_cell #(
			.TIME_WIDTH (TIME_WIDTH),
			.IW         (IW),
			.IDX        (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd[i]),
			.wr_id     (id_q),
			.wr_period (per_q),
			.up_vld    (cand_vld[i]),
			.up_time   (cand_time[i]),
			.up_id     (cand_id[i]),
			.up_idx    (cand_idx[i]),
			.dn_vld    (cand_vld[i+1]),
			.dn_time   (cand_time[i+1]),
			.dn_id     (cand_id[i+1]),
			.dn_idx    (cand_idx[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			count_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_BUSY;
						cnt_q   <= '0;
					end
				end
				ST_BUSY: begin
					if (finish) begin
						state_q <= ST_IDLE;
						if ((mode_q == pes_pkg::MODE_REGISTER) && !full) begin
							count_q <= count_q + CW'(1);
						end
					end else if (!target_hit) begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			mode_q <= mode;
			id_q   <= entry_id;
			per_q  <= period;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (finish) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			fired_id  <= '0;
			fire_time <= '0;
			if (mode_q == pes_pkg::MODE_REGISTER) begin
				status <= full ? pes_pkg::STATUS_FULL : pes_pkg::STATUS_REGISTERED;
			end else if (!cand_vld[ENTRIES]) begin
				status <= pes_pkg::STATUS_EMPTY;
			end else begin
				status    <= pes_pkg::STATUS_FIRED;
				fired_id  <= cand_id[ENTRIES];
				fire_time <= best_time64[pes_pkg::OUT_TIME_W-1:0];
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/pes_cell.sv =====
`default_nettype none
module pes_cell #(
	parameter int TIME_WIDTH = 48,
	parameter int IW         = 4,
	parameter int IDX        = 0
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire  pes_pkg::cell_cmd_t     cmd,
	input  wire  [pes_pkg::ID_W-1:0]     wr_id,
	input  wire  [pes_pkg::PERIOD_W-1:0] wr_period,
	input  wire                          up_vld,
	input  wire  [TIME_WIDTH-1:0]        up_time,
	input  wire  [pes_pkg::ID_W-1:0]     up_id,
	input  wire  [IW-1:0]                up_idx,
	output logic                         dn_vld,
	output logic [TIME_WIDTH-1:0]        dn_time,
	output logic [pes_pkg::ID_W-1:0]     dn_id,
	output logic [IW-1:0]                dn_idx
);

	logic                         vld_q;
	logic [pes_pkg::ID_W-1:0]     id_q;
	logic [pes_pkg::PERIOD_W-1:0] per_q;
	logic [TIME_WIDTH-1:0]        time_q;
	logic [TIME_WIDTH:0]          sum;
	logic [TIME_WIDTH-1:0]        time_adv;
	logic                         own_better;

	assign sum      = {1'b0, time_q} + (TIME_WIDTH+1)'(per_q);
	assign time_adv = sum[TIME_WIDTH] ? {TIME_WIDTH{1'b1}} : sum[TIME_WIDTH-1:0];

	// The slot passes its own entry only when {time, id} is strictly smaller: equal times go to the lower id.
	assign own_better = vld_q && (!up_vld || ({time_q, id_q} < {up_time, up_id}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (cmd.wr) begin
			vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			id_q   <= wr_id;
			per_q  <= wr_period;
			time_q <= TIME_WIDTH'(wr_period);
		end else if (cmd.adv) begin
			time_q <= time_adv;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dn_vld <= 1'b0;
		end else begin
			dn_vld <= own_better || up_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (own_better) begin
			dn_time <= time_q;
			dn_id   <= id_q;
			dn_idx  <= IW'(IDX);
		end else begin
			dn_time <= up_time;
			dn_id   <= up_id;
			dn_idx  <= up_idx;
		end
	end

endmodule
`default_nettype wire
